// File: hdl/js_byte_minifier_macros.svh
// Assertion macros shared by the minifier RTL.
// Used through `include by the modules that carry concurrent checks; needs clk and rst in scope.
`ifndef JS_BYTE_MINIFIER_MACROS_SVH
`define JS_BYTE_MINIFIER_MACROS_SVH
`ifndef SYNTHESIS
// check while out of reset
`define JSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check on every edge, reset included
`define JSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JSM_ASSERT(lbl, prop, msg)
`define JSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/jsm_pkg.sv
// Shared types, character codes and classifier functions of the minifier.
// No dependencies; imported by the lexer, the output buffer and the top level.
package jsm_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int GROUP_SLOTS = 4;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_STRING,
    MODE_LINE,
    MODE_BLOCK
  } lex_mode_t;

  typedef struct packed {
    lex_mode_t  mode;
    logic       regex_active;
    logic       escape_pending;
    logic [7:0] quote_kind;
    logic       star_seen;
    logic       slash_held;
    logic [7:0] byte_before_slash;
    logic [7:0] previous_byte;
    logic       seen_any;
    logic       last_word_like;
    logic       inside_identifier;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_mark;
  } item_t;

  // results of one input word: up to four items, lowest slot first
  typedef struct packed {
    logic [2:0]                   count;
    item_t [GROUP_SLOTS-1:0]      items;
  } group_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_quote(logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_BTICK);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic opens_regex(logic [7:0] p);
    logic r;
    unique case (p)
      8'h28, 8'h2C, 8'h3D, 8'h3A, 8'h5B, 8'h21, 8'h26, 8'h7C, 8'h3F,
      8'h2B, 8'h2D, 8'h7E, 8'h2A, 8'h2F, 8'h7B, 8'h7D, 8'h3B: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // append one item to a group
  function automatic group_t add_item(group_t g, logic [7:0] b, logic has, logic endm);
    group_t r;
    r = g;
    r.items[g.count[1:0]] = '{out_byte: b, has_byte: has, end_mark: endm};
    r.count = g.count + 3'd1;
    return r;
  endfunction

  // a held slash that opens no comment: clear the hold and settle the regex state
  function automatic lex_state_t release_slash(lex_state_t s);
    lex_state_t r;
    r = s;
    r.slash_held = 1'b0;
    if (!s.regex_active) begin
      if (opens_regex(s.byte_before_slash)) begin
        r.regex_active = 1'b1;
      end else begin
        r.last_word_like    = 1'b0;
        r.inside_identifier = 1'b0;
      end
    end else if (s.byte_before_slash != CH_BSLASH) begin
      r.regex_active = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/jsm_if.sv
// Valid/ready channel interfaces: source bytes in, minified items out.
// No dependencies.
interface jsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface jsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_mark;
  modport source (output valid, out_byte, has_byte, end_mark, input ready);
  modport sink (input valid, out_byte, has_byte, end_mark, output ready);
endinterface

// File: hdl/jsm_lex.sv
// Lexer state and the single-pass step that turns one source byte into a result group.
// Depends on jsm_pkg and the assertion macros.
`include "js_byte_minifier_macros.svh"
module jsm_lex (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  input  logic            step,
  input  logic [7:0]      in_byte,
  input  logic            end_of_input,
  output jsm_pkg::group_t grp
);
  import jsm_pkg::*;

  lex_state_t st;
  lex_state_t st_next;
  logic       comment_open;

  always_comb begin
    st_next      = st;
    grp          = '0;
    comment_open = 1'b0;
    if (enable) begin
      if (st_next.slash_held) begin
        if (in_byte == CH_SLASH) begin
          st_next.slash_held = 1'b0;
          st_next.mode       = MODE_LINE;
          comment_open       = 1'b1;
        end else if (in_byte == CH_STAR) begin
          st_next.slash_held = 1'b0;
          st_next.mode       = MODE_BLOCK;
          st_next.star_seen  = 1'b0;
          comment_open       = 1'b1;
        end else begin
          grp     = add_item(grp, CH_SLASH, 1'b1, 1'b0);
          st_next = release_slash(st_next);
        end
      end
      if (!comment_open) begin
        unique case (st_next.mode)
          MODE_LINE: begin
            if (in_byte == CH_LF) st_next.mode = MODE_NORMAL;
          end
          MODE_BLOCK: begin
            if (st_next.star_seen && (in_byte == CH_SLASH)) begin
              st_next.mode      = MODE_NORMAL;
              st_next.star_seen = 1'b0;
            end else begin
              st_next.star_seen = (in_byte == CH_STAR);
            end
          end
          MODE_STRING: begin
            grp = add_item(grp, in_byte, 1'b1, 1'b0);
            if (st_next.escape_pending) begin
              st_next.escape_pending = 1'b0;
            end else if (in_byte == st_next.quote_kind) begin
              st_next.mode       = MODE_NORMAL;
              st_next.quote_kind = 8'h00;
            end else if (in_byte == CH_BSLASH) begin
              st_next.escape_pending = 1'b1;
            end
          end
          MODE_NORMAL: begin
            if (st_next.regex_active && st_next.escape_pending) begin
              grp = add_item(grp, in_byte, 1'b1, 1'b0);
              st_next.escape_pending = 1'b0;
            end else if (!st_next.regex_active && is_quote(in_byte)) begin
              st_next.mode              = MODE_STRING;
              st_next.quote_kind        = in_byte;
              st_next.escape_pending    = 1'b0;
              st_next.inside_identifier = 1'b0;
              grp = add_item(grp, in_byte, 1'b1, 1'b0);
            end else if (in_byte == CH_SLASH) begin
              st_next.slash_held        = 1'b1;
              st_next.byte_before_slash = st.seen_any ? st.previous_byte : 8'h00;
              st_next.inside_identifier = 1'b0;
            end else if (st_next.regex_active) begin
              grp = add_item(grp, in_byte, 1'b1, 1'b0);
              if (in_byte == CH_BSLASH) st_next.escape_pending = 1'b1;
            end else if (is_blank(in_byte)) begin
              st_next.inside_identifier = 1'b0;
            end else if (is_letter(in_byte) || (in_byte == CH_UNDER) ||
                         (in_byte == CH_DOLLAR) ||
                         (st_next.inside_identifier && is_digit(in_byte))) begin
              // word after word: keep them apart with one space
              if (!st_next.inside_identifier && st_next.last_word_like) begin
                grp = add_item(grp, CH_SPACE, 1'b1, 1'b0);
              end
              grp = add_item(grp, in_byte, 1'b1, 1'b0);
              st_next.inside_identifier = 1'b1;
              st_next.last_word_like    = 1'b1;
            end else begin
              grp = add_item(grp, in_byte, 1'b1, 1'b0);
              st_next.inside_identifier = 1'b0;
              st_next.last_word_like    = is_digit(in_byte);
            end
          end
        endcase
      end
      st_next.previous_byte = in_byte;
      st_next.seen_any      = 1'b1;
    end else begin
      grp = add_item(grp, in_byte, 1'b1, 1'b0);
    end
    if (end_of_input) begin
      if (st_next.slash_held) begin
        grp     = add_item(grp, CH_SLASH, 1'b1, 1'b0);
        st_next = release_slash(st_next);
      end
      grp     = add_item(grp, 8'h00, 1'b0, 1'b1);
      st_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  // a slash is only ever held in plain code
  `JSM_ASSERT_ALWAYS(a_slash_in_code, st.slash_held |-> (st.mode == MODE_NORMAL), "slash held outside code mode")

endmodule

// File: hdl/jsm_outbuf.sv
// Four-slot result register: loads one group, hands items out one per handshake.
// Depends on jsm_pkg, jsm_if and the assertion macros.
`include "js_byte_minifier_macros.svh"
module jsm_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsm_pkg::group_t  grp,
  output logic             can_load,
  jsm_out_if.source        dst
);
  import jsm_pkg::*;

  item_t [GROUP_SLOTS-1:0] slot;
  logic  [2:0]             cnt;
  logic                    pop;

  assign pop      = dst.valid && dst.ready;
  assign can_load = (cnt == 3'd0) || ((cnt == 3'd1) && pop);

  assign dst.valid    = (cnt != 3'd0);
  assign dst.out_byte = slot[0].out_byte;
  assign dst.has_byte = slot[0].has_byte;
  assign dst.end_mark = slot[0].end_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  // payload: load a fresh group or advance by one slot
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp.items;
    end else if (pop) begin
      for (int i = 0; i < GROUP_SLOTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  `JSM_ASSERT(a_cnt_range, cnt <= 3'd4, "result buffer count out of range")
  `JSM_ASSERT(a_load_drained, load |-> ((cnt == 3'd0) || ((cnt == 3'd1) && pop)), "group loaded over pending items")
  `JSM_ASSERT(a_end_bare, (dst.valid && dst.end_mark) |-> !dst.has_byte, "end marker carries a byte")

endmodule

// File: hdl/js_byte_minifier.sv
// Top level of the streaming script minifier: input word register, lexer, result buffer.
// Depends on jsm_pkg, jsm_if, jsm_lex, jsm_outbuf and the assertion macros.
//
// Use:
//   src carries one source byte per word (in_byte, end_of_input marks the last byte).
//   dst carries result words: out_byte with has_byte = 1, or a bare closing word with
//   has_byte = 0 and end_mark = 1 after the last byte of each source text.
//   cfg_we / cfg_wdata write the enable bit (1 minifies, 0 copies bytes); write it only
//   while no word is in flight.
// Timing:
//   An accepted byte sits in the input register; the lexer step runs once the result
//   buffer can load, and the result group is registered into that buffer, which drives
//   dst from its first slot.
//   Each byte yields zero to four result words. While dst is ready it gives out one word
//   per cycle and plain text streams at one byte per cycle; a released slash, an inserted
//   space or the end marker each add one result word.
// Reset: rst (synchronous) empties both registers, returns the lexer to code mode and
//   clears enable.
// Stall: while dst is not ready the result buffer holds, the input register keeps its
//   byte, and src.ready drops once that register is full.
`include "js_byte_minifier_macros.svh"
module js_byte_minifier (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  jsm_in_if.sink    src,
  jsm_out_if.source dst
);
  import jsm_pkg::*;

  logic       enable;
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_last;
  logic       can_load;
  logic       step;
  logic       accept;
  group_t     grp;

  // advance the held byte whenever the result buffer is empty or drains its last word this cycle
  assign step      = inq_valid && can_load;
  assign src.ready = !inq_valid || step;
  assign accept    = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (accept) begin
      inq_valid <= 1'b1;
    end else if (step) begin
      inq_valid <= 1'b0;
    end
  end

  // hold the payload until the lexer takes it
  always_ff @(posedge clk) begin
    if (accept) begin
      inq_byte <= src.in_byte;
      inq_last <= src.end_of_input;
    end
  end

  jsm_lex u_lex (
    .clk          (clk),
    .rst          (rst),
    .enable       (enable),
    .step         (step),
    .in_byte      (inq_byte),
    .end_of_input (inq_last),
    .grp          (grp)
  );

  jsm_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .grp      (grp),
    .can_load (can_load),
    .dst      (dst)
  );

  // a held byte that cannot advance stays put
  `JSM_ASSERT(a_inq_hold,
              (inq_valid && !step) |=> (inq_valid && $stable(inq_byte) && $stable(inq_last)),
              "input register lost a pending byte")

endmodule
